// ===== src/gfdba_pkg.sv =====
// ----------------------------------------------------------------------------
// gfdba_pkg
// Shared types and constants for the gyro frame decoder with boxcar averaging.
// ----------------------------------------------------------------------------
`default_nettype none

package gfdba_pkg;

  localparam int WIN_W          = 11;
  localparam int CNT_W          = 11;
  localparam int RATE_W         = 24;
  localparam int TEMP_W         = 19;
  localparam int MAX_WINDOW_DEF = 1024;
  localparam int WINDOW_RESET   = 16;
  localparam int TEMP_OFFSET    = 8000;
  localparam int TEMP_DIVISOR   = 85;
  localparam int TEMP_BIAS      = 6400;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RATE,
    ST_TEMP,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== src/gfdba_div.sv =====
// ----------------------------------------------------------------------------
// gfdba_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module gfdba_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]    rem;
  logic [DEN_W-1:0]  divisor;
  logic [DEN_W:0]    rem_shift;
  logic [DEN_W:0]    diff;

  assign rem_shift = {rem[DEN_W-1:0], quot[NUM_W-1]};
  assign diff      = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(NUM_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        done  <= (steps == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot    <= num;
      rem     <= '0;
      divisor <= den;
    end else if (steps != '0) begin
      if (!diff[DEN_W]) begin
        rem  <= diff;
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/gyro_frame_decode_block_average.sv =====
// ----------------------------------------------------------------------------
// gyro_frame_decode_block_average
// Gyro frame decoder: drops invalid frames, sums the rate field and emits the
// window mean of the rate with the temperature of the last sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one frame per transaction:
//   status_rate_word and temperature_code. Output channel (out_valid/out_ready)
//   carries average_rate and temperature_fixed. Config channel
//   (cfg_valid/cfg_ready) writes window_size; write it only while idle.
//   A frame with data ready or self-test clear is dropped. Other frames are
//   summed; a frame that completes the window triggers one result.
//   Flow: a frame that does not complete the window is simply summed. A
//   completing frame runs two passes through the shared serial divider
//   (mean, then temperature) before out_valid rises; in_ready stays low
//   meanwhile.
//   A result waits in the output register while the receiver stalls; input
//   frames keep being taken until another result must be written.
//   Reset: window_size returns to 16, the sum and sample count clear, and
//   no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_frame_decode_block_average #(
  parameter int MAX_WINDOW = gfdba_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic        [gfdba_pkg::WIN_W-1:0]  window_size,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [31:0]                  status_rate_word,
  input  wire logic        [15:0]                  temperature_code,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [gfdba_pkg::RATE_W-1:0] average_rate,
  output logic signed      [gfdba_pkg::TEMP_W-1:0] temperature_fixed
);

  localparam int WIN_W  = gfdba_pkg::WIN_W;
  localparam int CNT_W  = gfdba_pkg::CNT_W;
  localparam int RATE_W = gfdba_pkg::RATE_W;
  localparam int TEMP_W = gfdba_pkg::TEMP_W;
  localparam int WIN_LIMIT = (1 << WIN_W) - 1;
  localparam int WMAX   = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;
  localparam int ACC_W  = RATE_W + $clog2(WMAX);

  localparam logic [WIN_W-1:0] WMAX_V   = WIN_W'(WMAX);
  localparam logic [ACC_W-1:0] POS_LIM  = ACC_W'((1 << (RATE_W - 1)) - 1);
  localparam logic [ACC_W-1:0] NEG_LIM  = ACC_W'(1 << (RATE_W - 1));
  localparam logic [WIN_W-1:0] TDIV     = WIN_W'(gfdba_pkg::TEMP_DIVISOR);

  gfdba_pkg::state_t state, state_next;

  logic [WIN_W-1:0]         window;
  logic signed [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]         count;
  logic                     rate_neg;
  logic                     temp_neg;
  logic [23:0]              temp_mag;
  logic [RATE_W-1:0]        avg_hold;

  logic                     frame_ok;
  logic                     accept;
  logic                     window_full;
  logic [WIN_W-1:0]         eff_window;
  logic signed [RATE_W-1:0] rate_s;
  logic signed [ACC_W-1:0]  acc_next;
  logic [CNT_W-1:0]         count_next;
  logic [ACC_W-1:0]         acc_mag;
  logic signed [16:0]       temp_diff;
  logic [16:0]              temp_abs;
  logic [RATE_W-1:0]        avg_value;
  logic signed [TEMP_W-1:0] temp_q;
  logic signed [TEMP_W-1:0] temp_value;
  logic                     load_out;

  logic                     div_start;
  logic [ACC_W-1:0]         div_num;
  logic [WIN_W-1:0]         div_den;
  logic                     div_done;
  logic [ACC_W-1:0]         div_quot;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (window == '0) begin
      eff_window = WIN_W'(1);
    end else if (window > WMAX_V) begin
      eff_window = WMAX_V;
    end else begin
      eff_window = window;
    end
  end

  assign frame_ok    = status_rate_word[31] & status_rate_word[0];
  assign rate_s      = $signed(status_rate_word[30:7]);
  assign acc_next    = acc + ACC_W'(rate_s);
  assign count_next  = count + 1'b1;
  assign window_full = (count_next >= CNT_W'(eff_window));
  assign acc_mag     = acc_next[ACC_W-1] ? ACC_W'(-acc_next) : ACC_W'(acc_next);
  assign accept      = in_valid & in_ready;

  assign temp_diff = $signed({1'b0, temperature_code}) - 17'sd8000;
  assign temp_abs  = temp_diff[16] ? 17'(-temp_diff) : 17'(temp_diff);

  always_comb begin
    if (rate_neg) begin
      avg_value = (div_quot > NEG_LIM) ? NEG_LIM[RATE_W-1:0]
                                       : RATE_W'(-div_quot[RATE_W-1:0]);
    end else begin
      avg_value = (div_quot > POS_LIM) ? POS_LIM[RATE_W-1:0] : div_quot[RATE_W-1:0];
    end
  end

  assign temp_q     = $signed(div_quot[TEMP_W-1:0]);
  assign temp_value = (temp_neg ? -temp_q : temp_q) + TEMP_W'(gfdba_pkg::TEMP_BIAS);
  assign load_out   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    div_num    = ACC_W'(temp_mag);
    div_den    = TDIV;
    unique case (state)
      gfdba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        div_num  = acc_mag;
        div_den  = eff_window;
        if (in_valid && frame_ok && window_full) begin
          div_start  = 1'b1;
          state_next = gfdba_pkg::ST_RATE;
        end
      end
      gfdba_pkg::ST_RATE: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = gfdba_pkg::ST_TEMP;
        end
      end
      gfdba_pkg::ST_TEMP: begin
        if (div_done) begin
          state_next = gfdba_pkg::ST_OUT;
        end
      end
      gfdba_pkg::ST_OUT: begin
        if (load_out) begin
          state_next = gfdba_pkg::ST_IDLE;
        end
      end
      default: state_next = gfdba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= gfdba_pkg::ST_IDLE;
      window <= WIN_W'(gfdba_pkg::WINDOW_RESET);
      acc    <= '0;
      count  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        window <= window_size;
      end
      if (accept && frame_ok) begin
        if (window_full) begin
          acc   <= '0;
          count <= '0;
        end else begin
          acc   <= acc_next;
          count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_ok && window_full) begin
      rate_neg <= acc_next[ACC_W-1];
      temp_neg <= temp_diff[16];
      temp_mag <= {temp_abs[15:0], 8'h00};
    end
    if (state == gfdba_pkg::ST_RATE && div_done) begin
      avg_hold <= avg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == gfdba_pkg::ST_OUT && load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gfdba_pkg::ST_OUT && load_out) begin
      average_rate      <= $signed(avg_hold);
      temperature_fixed <= temp_value;
    end
  end

  gfdba_div #(
    .NUM_W (ACC_W),
    .DEN_W (WIN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

`default_nettype wire

// ===== dv/gyro_frame_decode_block_average_tb.sv =====
// ----------------------------------------------------------------------------
// gyro_frame_decode_block_average_tb
// Self-checking bench for the gyro frame decoder with boxcar averaging.
// Frames are driven in random bursts and gaps. Each accepted frame goes
// through a local model of the decoder that queues the expected mean rate and
// temperature. Results taken from the output under random back-pressure are
// checked against that queue. The window register is rewritten between
// phases while the block is idle. This covers zero, oversized and lowered
// windows, saturation of the mean, and many random window sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_frame_decode_block_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WIN_W          = gfdba_pkg::WIN_W;
  localparam int     CNT_W          = gfdba_pkg::CNT_W;
  localparam int     RATE_W         = gfdba_pkg::RATE_W;
  localparam int     TEMP_W         = gfdba_pkg::TEMP_W;
  localparam int     MAX_WINDOW_DEF = gfdba_pkg::MAX_WINDOW_DEF;
  localparam int     WINDOW_RESET   = gfdba_pkg::WINDOW_RESET;
  localparam longint TEMP_OFFSET    = longint'(gfdba_pkg::TEMP_OFFSET);
  localparam longint TEMP_DIVISOR   = longint'(gfdba_pkg::TEMP_DIVISOR);
  localparam longint TEMP_BIAS      = longint'(gfdba_pkg::TEMP_BIAS);

  localparam int    SETTLE_CYCLES = 100;
  localparam longint RATE_MAX     = (64'sd1 <<< (RATE_W - 1)) - 1;
  localparam longint RATE_MIN     = -RATE_MAX - 1;

  typedef enum logic [1:0] {
    K_FRAME,
    K_WINDOW,
    K_DRAIN
  } stim_kind_t;

  typedef struct packed {
    stim_kind_t        kind;
    logic [31:0]       word;
    logic [15:0]       code;
    logic [WIN_W-1:0]  win;
  } stim_step_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] mean;
    logic signed [TEMP_W-1:0] temp;
  } window_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [WIN_W-1:0]         window_size = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [31:0]              status_rate_word = '0;
  logic [15:0]              temperature_code = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [RATE_W-1:0] average_rate;
  logic signed [TEMP_W-1:0] temperature_fixed;

  stim_step_t     pending[$];
  window_result_t mean_expect[$];

  // local copy of the decoder state
  logic [WIN_W-1:0] win_reg = WIN_W'(WINDOW_RESET);
  longint           rate_sum = 0;
  logic [CNT_W-1:0] sample_cnt = '0;

  int burst_left = 1;
  int gap_left = 0;
  int quiet_cycles = 0;
  int frames_sent = 0;
  int frames_dropped = 0;
  int results_checked = 0;
  int window_writes = 0;
  int err_count = 0;

  int ready_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  gyro_frame_decode_block_average uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .window_size       (window_size),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .status_rate_word  (status_rate_word),
    .temperature_code  (temperature_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .average_rate      (average_rate),
    .temperature_fixed (temperature_fixed)
  );

  always #10 clk = ~clk;

  function automatic void predict_frame(input logic [31:0] word, input logic [15:0] code);
    logic signed [RATE_W-1:0] rate;
    longint                   eff;
    longint                   mean;
    longint                   temp;
    window_result_t           res;
    if (!word[31] || !word[0]) begin
      frames_dropped++;
      return;
    end
    rate = word[30:7];
    rate_sum = rate_sum + longint'(rate);
    sample_cnt = sample_cnt + 1'b1;
    eff = longint'(win_reg);
    if (eff == 0) eff = 1;
    if (eff > longint'(MAX_WINDOW_DEF)) eff = longint'(MAX_WINDOW_DEF);
    if (longint'(sample_cnt) < eff) return;
    mean = rate_sum / eff;
    if (mean > RATE_MAX) mean = RATE_MAX;
    if (mean < RATE_MIN) mean = RATE_MIN;
    temp = ((longint'(code) - TEMP_OFFSET) * 256) / TEMP_DIVISOR + TEMP_BIAS;
    res.mean = mean[RATE_W-1:0];
    res.temp = temp[TEMP_W-1:0];
    mean_expect.push_back(res);
    rate_sum = 0;
    sample_cnt = '0;
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready) predict_frame(status_rate_word, temperature_code);
      if (cfg_valid && cfg_ready) begin
        win_reg = window_size;
        window_writes++;
      end
      if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
        // hold until the transaction is taken
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        gap_left--;
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (pending[0].kind == K_FRAME) begin
        cfg_valid <= 1'b0;
        in_valid <= 1'b1;
        status_rate_word <= pending[0].word;
        temperature_code <= pending[0].code;
        pending.delete(0);
        frames_sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 4))
            0, 1:    gap_left = 0;
            2, 3:    gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 90);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
        if (mean_expect.size() == 0) quiet_cycles++;
        else quiet_cycles = 0;
        if (pending[0].kind == K_DRAIN && quiet_cycles != 0) begin
          cfg_valid <= 1'b0;
          pending.delete(0);
          quiet_cycles = 0;
        end else if (pending[0].kind == K_WINDOW && quiet_cycles >= SETTLE_CYCLES) begin
          cfg_valid <= 1'b1;
          window_size <= pending[0].win;
          pending.delete(0);
          quiet_cycles = 0;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
    end else begin
      case (ready_mode)
        0: begin
          out_ready <= 1'b1;
          hold_left = 0;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
          hold_left = $urandom_range(0, 2);
        end
        2: begin
          out_ready <= ($urandom_range(0, 7) != 0);
          hold_left = 0;
        end
        default: begin
          out_ready <= !out_ready;
          hold_left = out_ready ? $urandom_range(10, 100) : $urandom_range(0, 4);
        end
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    window_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (mean_expect.size() == 0) begin
        report_error($sformatf("unexpected result average_rate=%0d temperature_fixed=%0d",
                               average_rate, temperature_fixed));
      end else begin
        exp_res = mean_expect.pop_front();
        results_checked++;
        if (average_rate !== exp_res.mean)
          report_error($sformatf("average_rate expected %0d got %0d",
                                 exp_res.mean, average_rate));
        if (temperature_fixed !== exp_res.temp)
          report_error($sformatf("temperature_fixed expected %0d got %0d",
                                 exp_res.temp, temperature_fixed));
      end
    end
  end

  function automatic logic [31:0] good_word(input logic [23:0] rate);
    logic [5:0] pad;
    pad = 6'($urandom);
    return {1'b1, rate, pad, 1'b1};
  endfunction

  function automatic logic [23:0] random_rate();
    case ($urandom_range(0, 9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'($signed($urandom_range(0, 6)) - 3);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_code();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_frame(input logic [31:0] word, input logic [15:0] code);
    stim_step_t s;
    s = '{kind: K_FRAME, word: word, code: code, win: '0};
    pending.push_back(s);
  endtask

  task automatic push_window(input logic [WIN_W-1:0] w);
    stim_step_t s;
    s = '{kind: K_WINDOW, word: '0, code: '0, win: w};
    pending.push_back(s);
  endtask

  task automatic push_drain();
    stim_step_t s;
    s = '{kind: K_DRAIN, word: '0, code: '0, win: '0};
    pending.push_back(s);
  endtask

  initial begin
    int               rand_frames;
    int               est_results;
    int               phase_good;
    int               n;
    int               eff;
    logic [WIN_W-1:0] w;

    rand_frames = 0;
    est_results = 0;

    // directed: reset window partly filled, then extremes of every field
    push_frame(good_word(24'h000010), 16'd8000);
    push_frame(good_word(24'hFFFFF0), 16'd8000);
    push_window(11'd1);
    push_frame(good_word(24'h7FFFFF), 16'h0000);
    push_frame(good_word(24'h800000), 16'hFFFF);
    push_frame(good_word(24'h000000), 16'd8000);
    push_frame(good_word(24'hFFFFFF), 16'd7999);
    push_frame({1'b0, 30'h2AAAAAAA, 1'b1}, 16'd1234);
    push_frame({1'b1, 30'h15555555, 1'b0}, 16'd4321);
    push_frame(32'h00000000, 16'h0000);
    push_frame(32'hFFFFFFFF, 16'd8001);
    push_window(11'd0);
    push_frame(good_word(24'h123456), 16'd100);
    push_frame(good_word(24'hEDCBA9), 16'd60000);
    // lower the window mid-window: saturate high, then low
    push_window(11'd4);
    repeat (3) push_frame(good_word(24'h7FFFFF), 16'd9000);
    push_window(11'd1);
    push_frame(good_word(24'h7FFFFF), 16'd9000);
    push_window(11'd4);
    repeat (3) push_frame(good_word(24'h800000), 16'd7000);
    push_window(11'd2);
    push_frame(good_word(24'h800000), 16'd7000);
    // truncation toward zero on negative sums
    push_window(11'd3);
    push_frame(good_word(24'hFFFFF8), 16'd8085);
    push_frame(good_word(24'h000000), 16'd8085);
    push_frame(good_word(24'h000000), 16'd7915);
    push_drain();

    // random phases, mostly small windows
    while (rand_frames < 830 || est_results < 48) begin
      case ($urandom_range(0, 19))
        0:          w = '0;
        1:          w = WIN_W'($urandom_range(41, 200));
        2, 3, 4, 5: w = WIN_W'($urandom_range(9, 40));
        default:    w = WIN_W'($urandom_range(1, 8));
      endcase
      eff = (w == 0) ? 1 : int'(w);
      push_window(w);
      n = $urandom_range(8, 60);
      phase_good = 0;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          push_frame($urandom, random_code());
        end else begin
          push_frame(good_word(random_rate()), random_code());
          phase_good++;
        end
        if ($urandom_range(0, 79) == 0) push_drain();
      end
      rand_frames += n;
      est_results += phase_good / eff;
    end

    // oversized window: no result while the count stays below the maximum
    push_window('1);
    repeat (40) push_frame(good_word(random_rate()), random_code());
    push_window(11'd8);
    push_frame(good_word(random_rate()), random_code());

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (pending.size() != 0 || in_valid || cfg_valid);
    do @(negedge clk); while (mean_expect.size() != 0);
    repeat (150) @(negedge clk);

    $display("Sent %0d frames (%0d dropped) over %0d window writes; checked %0d results.",
             frames_sent, frames_dropped, window_writes, results_checked);
    $display("Windows ran from zero to the register maximum; %0d errors logged.", err_count);
    if (err_count == 0) begin
      $display("** gyro_frame_decode_block_average: PASSED **");
    end else begin
      $display("** gyro_frame_decode_block_average: FAILED **");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results still expected.", mean_expect.size());
    $display("** gyro_frame_decode_block_average: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/gfdba_pkg.sv
src/gfdba_div.sv
src/gyro_frame_decode_block_average.sv
dv/gyro_frame_decode_block_average_tb.sv
